/* rtl/core/bbpa_pkg.sv */
// Package for the band probability amplifier core: widths, register indexes,
// state encodings and fixed constants. No dependencies.
package bbpa_pkg;

	localparam int HistDepth = 64;
	localparam int PtrW      = 6;
	localparam int CntW      = 7;
	localparam int PriceW    = 32;
	localparam int SumW      = 38;
	localparam int SqW       = 70;
	localparam int SdW       = 33;
	localparam int CfgIdxW   = 3;
	localparam int CfgDataW  = 16;

	localparam logic [16:0] ProbLo    = 17'd3277;
	localparam logic [16:0] ProbHi    = 17'd62259;
	localparam logic [16:0] ProbHalf  = 17'd32768;
	localparam logic [16:0] ExtraPush = 17'd3277;
	localparam logic [16:0] OneQ16    = 17'd65536;

	typedef enum logic [CfgIdxW-1:0] {
		REG_WINDOW = 3'd0,
		REG_MULT   = 3'd1,
		REG_THRESH = 3'd2,
		REG_GAIN   = 3'd3,
		REG_ENABLE = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_MEAN,
		ST_SQ,
		ST_SQMUL,
		ST_VAR,
		ST_ROOT,
		ST_BAND,
		ST_POS,
		ST_AMP_MUL,
		ST_AMP_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;

endpackage

/* rtl/core/bbpa_if.sv */
// Valid/ready channel interface with payload; used by the core top level.
// Depends on nothing; payload width set per instance.
interface bbpa_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/bbpa_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module bbpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write then registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* rtl/core/bbpa_div.sv */
// Restoring divider, one quotient bit a cycle, 70-bit dividend, 46-bit divisor.
// Depends on bbpa_pkg.
module bbpa_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [69:0]             dividend,
	input  logic [45:0]             divisor,
	output bbpa_pkg::div_ctl_t      ctl,
	output logic [69:0]             quotient
);
	logic [6:0]  cnt_q;
	logic [46:0] rem_q;
	logic [69:0] quo_q;
	logic [45:0] dvs_q;
	logic [46:0] trial;
	logic [46:0] shifted;

	assign shifted = {rem_q[45:0], quo_q[69]};
	assign trial   = shifted - {1'b0, dvs_q};

	// iterate one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 7'd70;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[46]) begin
				rem_q <= trial;
				quo_q <= {quo_q[68:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[68:0], 1'b0};
			end
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = (cnt_q != '0) || start;
	assign quotient  = quo_q;
endmodule

/* rtl/core/bollinger_band_probability_amplifier_core.sv */
// Bollinger band percent-b probability amplifier core. One item at a time:
// an input beat is taken only while the core is idle and no result waits.
// From input beat to result beat the core makes two passes over the history RAM
// (one read a cycle), up to four runs of the serial divider (mean, variance,
// band position, probability shift) and a bit-serial square root. With fewer
// than L closes held (L = window length) the core skips these steps and goes
// straight to the result beat.
// The next input beat is taken from the cycle after the result beat.
// Depends on bbpa_pkg, bbpa_if, bbpa_ram, bbpa_div.
module bollinger_band_probability_amplifier_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [15:0]           cfg_data,
	bbpa_if.sink                  in_ch,
	bbpa_if.source                out_ch
);
	// in_ch.data  = {close_price[31:0], base_prob[15:0]}
	// out_ch.data = {middle_band, upper_band, lower_band, band_position,
	//                adjusted_probability, bands_valid}

	bbpa_pkg::state_t state_q, state_next;

	logic [6:0]  win_q;
	logic [11:0] mult_q;
	logic [15:0] thr_q;
	logic [15:0] gain_q;
	logic        en_q;

	logic [5:0]  wptr_q;
	logic [6:0]  count_q;
	logic [31:0] close_q;
	logic [15:0] base_q;
	logic [6:0]  len_q;
	logic [6:0]  idx_q;
	logic        rd_vld_q;
	logic [37:0] sum_q;
	logic [31:0] mean_q;
	logic [69:0] sq_q;
	logic [31:0] diff_q;
	logic        diff_vld_q;
	logic [63:0] prod_q;
	logic        prod_vld_q;
	logic [69:0] var_q;
	logic [32:0] root_q;
	logic [6:0]  bit_q;
	logic [44:0] off8_q;
	logic [16:0] pos_q;
	logic        valid_q;
	logic [33:0] up_q;
	logic [33:0] lo_q;
	logic [18:0] prob_q;
	logic [32:0] shift_num_q;
	logic        amp_up_q;
	logic        amp_dn_q;
	logic        extra_q;
	logic        out_valid_q;
	logic [133:0] out_data_q;

	logic [6:0]  len_eff;
	logic [5:0]  raddr;
	logic [31:0] rdata;
	logic        accept;

	logic        div_start;
	logic [69:0] div_dividend;
	logic [45:0] div_divisor;
	bbpa_pkg::div_ctl_t div_ctl;
	logic [69:0] div_quot;
	logic        div_started_q;

	assign accept      = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == bbpa_pkg::ST_IDLE) && !out_valid_q;

	assign len_eff = (win_q < 7'd2) ? 7'd2 : ((win_q > 7'd64) ? 7'd64 : win_q);

	// walk back from the newest entry
	assign raddr = wptr_q - 6'd1 - idx_q[5:0];

	bbpa_ram #(.WIDTH(bbpa_pkg::PriceW), .DEPTH(bbpa_pkg::HistDepth)) u_hist (
		.clk   (clk),
		.we    (accept),
		.waddr (wptr_q),
		.wdata (in_ch.data[47:16]),
		.raddr (raddr),
		.rdata (rdata)
	);

	bbpa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.ctl      (div_ctl),
		.quotient (div_quot)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= 7'd20;
			mult_q <= 12'd512;
			thr_q  <= 16'd19661;
			gain_q <= 16'd6554;
			en_q   <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bbpa_pkg::REG_WINDOW: win_q  <= cfg_data[6:0];
				bbpa_pkg::REG_MULT:   mult_q <= cfg_data[11:0];
				bbpa_pkg::REG_THRESH: thr_q  <= cfg_data;
				bbpa_pkg::REG_GAIN:   gain_q <= cfg_data;
				bbpa_pkg::REG_ENABLE: en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// position numerator and bandwidth; divide only strictly inside the bands
	logic signed [46:0] num_s;
	logic [45:0]        bw8;
	logic               pos_div;
	assign num_s = $signed({7'd0, close_q, 8'd0}) - $signed({7'd0, mean_q, 8'd0})
		+ $signed({2'd0, off8_q});
	assign bw8 = {off8_q, 1'b0};
	assign pos_div = (off8_q != '0) && (num_s > 0) && ($unsigned(num_s[45:0]) < bw8);

	// next state
	logic pass_done;
	assign pass_done = (idx_q == len_q) && !rd_vld_q;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			bbpa_pkg::ST_IDLE:
				if (accept) state_next = bbpa_pkg::ST_SUM;
			bbpa_pkg::ST_SUM:
				if (count_q < len_q) state_next = bbpa_pkg::ST_DONE;
				else if (pass_done) state_next = bbpa_pkg::ST_MEAN;
			bbpa_pkg::ST_MEAN:
				if (div_started_q && !div_ctl.busy) state_next = bbpa_pkg::ST_SQ;
			bbpa_pkg::ST_SQ:
				if (pass_done && !diff_vld_q) state_next = bbpa_pkg::ST_SQMUL;
			bbpa_pkg::ST_SQMUL:
				if (!prod_vld_q) state_next = bbpa_pkg::ST_VAR;
			bbpa_pkg::ST_VAR:
				if (div_started_q && !div_ctl.busy) state_next = bbpa_pkg::ST_ROOT;
			bbpa_pkg::ST_ROOT:
				if (bit_q == 7'd127) state_next = bbpa_pkg::ST_BAND;
			bbpa_pkg::ST_BAND:
				state_next = bbpa_pkg::ST_POS;
			bbpa_pkg::ST_POS:
				if (off8_q == '0) state_next = bbpa_pkg::ST_DONE;
				else if (!pos_div || (div_started_q && !div_ctl.busy))
					state_next = bbpa_pkg::ST_AMP_MUL;
			bbpa_pkg::ST_AMP_MUL:
				state_next = bbpa_pkg::ST_AMP_DIV;
			bbpa_pkg::ST_AMP_DIV:
				if (!(amp_up_q || amp_dn_q) || (div_started_q && !div_ctl.busy))
					state_next = bbpa_pkg::ST_DONE;
			bbpa_pkg::ST_DONE:
				state_next = bbpa_pkg::ST_IDLE;
			default: state_next = bbpa_pkg::ST_IDLE;
		endcase
	end

	// divider operands per phase
	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		unique case (state_q)
			bbpa_pkg::ST_MEAN: begin
				div_start    = !div_started_q;
				div_dividend = {32'd0, sum_q};
				div_divisor  = {39'd0, len_q};
			end
			bbpa_pkg::ST_VAR: begin
				div_start    = !div_started_q;
				div_dividend = sq_q;
				div_divisor  = {39'd0, len_q};
			end
			bbpa_pkg::ST_POS: begin
				div_start    = pos_div && !div_started_q;
				div_dividend = {8'd0, num_s[45:0], 16'd0};
				div_divisor  = bw8;
			end
			bbpa_pkg::ST_AMP_DIV: begin
				div_start    = (amp_up_q || amp_dn_q) && !div_started_q;
				div_dividend = {37'd0, shift_num_q};
				div_divisor  = {30'd0, thr_q};
			end
			default: ;
		endcase
	end

	// square root trial
	logic [32:0] root_c;
	logic [65:0] root_sq;
	assign root_c  = root_q | (33'd1 << bit_q[5:0]);
	assign root_sq = root_c * root_c;

	// band saturation: floor of Q.8 to 34-bit signed
	logic signed [47:0] up8, lo8;
	logic signed [39:0] up_f, lo_f;
	assign up8  = $signed({8'd0, mean_q, 8'd0}) + $signed({3'd0, off8_q});
	assign lo8  = $signed({8'd0, mean_q, 8'd0}) - $signed({3'd0, off8_q});
	assign up_f = up8[47:8];
	assign lo_f = lo8[47:8];

	function automatic logic [33:0] sat34(input logic signed [39:0] v);
		if (v > 40'sd8589934591) return 34'h1_FFFF_FFFF;
		else if (v < -40'sd8589934592) return 34'h2_0000_0000;
		else return v[33:0];
	endfunction

	logic signed [18:0] pos_s, thr_s, edge_s, dn_s;
	assign pos_s  = $signed({2'd0, pos_q});
	assign thr_s  = $signed({3'd0, thr_q});
	assign edge_s = $signed(19'd65536) - thr_s;
	assign dn_s   = pos_s - edge_s;

	// clamp of the final probability, held signed so a push past zero clamps low
	logic signed [18:0] prob_s;
	logic [16:0]        prob_c;
	always_comb begin
		prob_s = $signed(prob_q);
		prob_c = prob_q[16:0];
		if (valid_q && en_q) begin
			if (prob_s < $signed({2'd0, bbpa_pkg::ProbLo})) prob_c = bbpa_pkg::ProbLo;
			else if (prob_s > $signed({2'd0, bbpa_pkg::ProbHi})) prob_c = bbpa_pkg::ProbHi;
		end
	end

	logic [16:0] push;
	logic [16:0] shift_amt;
	assign shift_amt = div_quot[16:0];
	assign push      = extra_q ? bbpa_pkg::ExtraPush : 17'd0;

	// datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= bbpa_pkg::ST_IDLE;
			wptr_q        <= '0;
			count_q       <= '0;
			out_valid_q   <= 1'b0;
			div_started_q <= 1'b0;
			rd_vld_q      <= 1'b0;
			diff_vld_q    <= 1'b0;
			prod_vld_q    <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_next != state_q) div_started_q <= 1'b0;
			else if (div_start) div_started_q <= 1'b1;
			if (state_q == bbpa_pkg::ST_DONE) out_valid_q <= 1'b1;
			else if (out_ch.valid && out_ch.ready) out_valid_q <= 1'b0;
			if (accept) begin
				wptr_q <= wptr_q + 6'd1;
				if (count_q < 7'd64) count_q <= count_q + 7'd1;
			end
			rd_vld_q   <= ((state_q == bbpa_pkg::ST_SUM) || (state_q == bbpa_pkg::ST_SQ))
				&& (idx_q != len_q);
			diff_vld_q <= (state_q == bbpa_pkg::ST_SQ) && rd_vld_q;
			prod_vld_q <= diff_vld_q;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q) inside
			bbpa_pkg::ST_IDLE: begin
				close_q <= in_ch.data[47:16];
				base_q  <= in_ch.data[15:0];
				prob_q  <= {3'b0, in_ch.data[15:0]};
				len_q   <= len_eff;
				idx_q   <= '0;
				sum_q   <= '0;
				sq_q    <= '0;
				mean_q  <= '0;
				off8_q  <= '0;
				pos_q   <= bbpa_pkg::ProbHalf;
				valid_q <= 1'b0;
				up_q    <= '0;
				lo_q    <= '0;
				root_q  <= '0;
				bit_q   <= 7'd32;
			end
			bbpa_pkg::ST_SUM: begin
				if (idx_q != len_q) idx_q <= idx_q + 7'd1;
				if (rd_vld_q) sum_q <= sum_q + {6'd0, rdata};
			end
			bbpa_pkg::ST_MEAN: begin
				mean_q <= div_quot[31:0];
				idx_q  <= '0;
			end
			bbpa_pkg::ST_SQ, bbpa_pkg::ST_SQMUL: begin
				if (idx_q != len_q && state_q == bbpa_pkg::ST_SQ) idx_q <= idx_q + 7'd1;
				if (rd_vld_q) diff_q <= (rdata >= mean_q) ? rdata - mean_q : mean_q - rdata;
				if (diff_vld_q) prod_q <= diff_q * diff_q;
				if (prod_vld_q) sq_q <= sq_q + {6'd0, prod_q};
			end
			bbpa_pkg::ST_VAR: var_q <= div_quot;
			bbpa_pkg::ST_ROOT: begin
				if (bit_q != 7'd127) begin
					if ({4'd0, root_sq} <= var_q) root_q <= root_c;
					bit_q <= bit_q - 7'd1;
				end
			end
			bbpa_pkg::ST_BAND: begin
				off8_q  <= root_q * mult_q;
			end
			bbpa_pkg::ST_POS: begin
				up_q    <= sat34(up_f);
				lo_q    <= sat34(lo_f);
				valid_q <= off8_q != '0;
				if (off8_q != '0) begin
					if (num_s <= 0) pos_q <= '0;
					else if ($unsigned(num_s[45:0]) >= bw8) pos_q <= bbpa_pkg::OneQ16;
					else pos_q <= div_quot[16:0];
				end
			end
			bbpa_pkg::ST_AMP_MUL: begin
				amp_up_q <= 1'b0;
				amp_dn_q <= 1'b0;
				extra_q  <= 1'b0;
				if (en_q && thr_q != '0) begin
					if (base_q > 16'd32768 && pos_s <= thr_s) begin
						amp_up_q    <= 1'b1;
						shift_num_q <= {1'b0, {16'd0, gain_q} * {16'd0, thr_q - pos_q[15:0]}};
						extra_q     <= ({pos_q, 3'd0} + {2'd0, pos_q, 1'b0}) < 21'd65536;
					end else if (base_q < 16'd32768 && pos_s >= edge_s) begin
						amp_dn_q    <= 1'b1;
						shift_num_q <= {1'b0, {16'd0, gain_q} * {16'd0, dn_s[15:0]}};
						extra_q     <= ({pos_q, 3'd0} + {2'd0, pos_q, 1'b0}) > 21'd589824;
					end
				end
			end
			bbpa_pkg::ST_AMP_DIV: begin
				if (div_started_q && !div_ctl.busy) begin
					if (amp_up_q) prob_q <= prob_q + {2'd0, shift_amt} + {2'd0, push};
					else prob_q <= prob_q - {2'd0, shift_amt} - {2'd0, push};
				end
			end
			bbpa_pkg::ST_DONE: begin
				out_data_q <= {mean_q, up_q, lo_q, pos_q, prob_c[15:0], valid_q};
			end
			default: ;
		endcase
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_data_q;

	// a beat is taken only while the core is idle
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> state_q == bbpa_pkg::ST_IDLE) else $error("accept while busy");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bbpa_pkg::ST_DONE |-> !out_valid_q) else $error("result overrun");
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bbpa_pkg::ST_DONE |=> out_valid_q) else $error("result lost");
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 7'd64) else $error("count overflow");
endmodule
